FILE: rtl/packed_palette_sprite_blitter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packed palette sprite blitter
// Immediate-clock concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PACKED_PALETTE_SPRITE_BLITTER_CORE_ASSERT_SVH
`define PACKED_PALETTE_SPRITE_BLITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every edge.
`define PPSB_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// Condition in one cycle implies result in the next.
`define PPSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define PPSB_ASSERT(lbl, cond, msg)
`define PPSB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/ppsb_pkg.sv
// ----------------------------------------------------------------------------
// Packed palette sprite blitter package
// Shared constants, codes and small decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsb_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int CLIP_RIGHT    = 255;

    localparam logic [8:0]  NO_SLOT    = 9'h1FF;
    localparam logic [15:0] OPAQUE_BIT = 16'h8000;

    // operation codes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_PALETTE = 2'd1;
    localparam logic [1:0] OP_DATA    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_WIDTH       = 3'd0;
    localparam logic [2:0] REG_HEIGHT      = 3'd1;
    localparam logic [2:0] REG_PAL_COUNT   = 3'd2;
    localparam logic [2:0] REG_TRANSPARENT = 3'd3;
    localparam logic [2:0] REG_COLOR_MASK  = 3'd4;
    localparam logic [2:0] REG_INVERT      = 3'd5;
    localparam logic [2:0] REG_ITALIC      = 3'd6;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd7;

    // bits per packed index from the palette size
    function automatic logic [3:0] index_bits(input logic [8:0] count);
        logic [3:0] b;
        if (count < 9'd3)        b = 4'd1;
        else if (count < 9'd5)   b = 4'd2;
        else if (count < 9'd9)   b = 4'd3;
        else if (count < 9'd17)  b = 4'd4;
        else if (count < 9'd33)  b = 4'd5;
        else if (count < 9'd65)  b = 4'd6;
        else if (count < 9'd129) b = 4'd7;
        else                     b = 4'd8;
        return b;
    endfunction

    function automatic logic [7:0] index_mask(input logic [3:0] bits);
        logic [8:0] m;
        m = (9'd1 << bits) - 9'd1;
        return m[7:0];
    endfunction

    // exact v/3 for any 9-bit v: multiply by 171, drop 9 bits
    function automatic logic [7:0] div3(input logic [8:0] v);
        logic [16:0] p;
        p = 17'(v) * 17'd171;
        return p[16:9];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/packed_palette_sprite_blitter_core.sv
// ----------------------------------------------------------------------------
// Packed palette sprite blitter core
// Unpacks a bit-packed palette sprite stream into clipped screen pixel writes.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                          | tuser / tlast
//  s_axis   | in  | pos_x 10, pos_y 10, palette_index 8,        | tuser: operation
//           |     | palette_color 16, packed_byte 8 (56 bits)   |
//  m_axis   | out | pixel_x 8, pixel_y 8, pixel_color 16        | tlast: last
//  cfg      | in  | i_cfg_we, i_cfg_index 3, i_cfg_data 16      | -
//
// Each data byte yields 1 to 8 indices; the unpack step takes one index a cycle
// while the output is not stalled. A new input word is accepted only when the
// step is idle or on the byte's final index. A pixel goes from the palette read
// into the hold stage, then to the output register; it waits in the hold stage
// for the next drawn index or the byte's final index, so that tlast is known.
// Synchronous active-low reset clears control state; palette RAM is undefined
// until written. Output backpressure freezes the unpack step and pixel hold.
`default_nettype none
`include "packed_palette_sprite_blitter_core_assert.svh"

module packed_palette_sprite_blitter_core
    import ppsb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x[9:0], pos_y[19:10], palette_index[27:20], palette_color[43:28],
    // packed_byte[51:44], zero fill[55:52]
    input  wire logic [55:0] s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_x[7:0], pixel_y[15:8], pixel_color[31:16]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // configuration
    logic [8:0]  r_cfg_width, r_cfg_height, r_cfg_pal_count;
    logic [15:0] r_cfg_trans, r_cfg_mask;
    logic        r_cfg_invert, r_cfg_italic;
    logic [7:0]  r_cfg_clip_bottom;

    // unpack state
    logic [15:0] r_pal_mem [PALETTE_DEPTH];
    logic [8:0]  r_trans_slot, n_trans_slot;
    logic [15:0] r_holder, n_holder;
    logic [4:0]  r_held, n_held;
    logic [8:0]  r_row, n_row;
    logic [8:0]  r_col, n_col;
    logic [7:0]  r_slant, n_slant;
    logic signed [10:0] r_origin_x, n_origin_x;
    logic signed [9:0]  r_origin_row, n_origin_row;
    logic        r_draw_on, n_draw_on;
    logic        r_busy, n_busy;
    logic [3:0]  r_taken, n_taken;

    // pixel hold and output
    logic        r_p_valid, r_p_last;
    logic [7:0]  r_p_x, r_p_y;
    logic [15:0] r_p_entry;
    logic        r_out_valid, r_out_last;
    logic [7:0]  r_out_x, r_out_y;
    logic [15:0] r_out_color;

    // input fields
    logic [1:0]  in_op;
    logic [9:0]  in_pos_x, in_pos_y;
    logic [7:0]  in_pal_idx, in_byte;
    logic [15:0] in_pal_color;

    assign in_op        = s_axis_tuser;
    assign in_pos_x     = s_axis_tdata[9:0];
    assign in_pos_y     = s_axis_tdata[19:10];
    assign in_pal_idx   = s_axis_tdata[27:20];
    assign in_pal_color = s_axis_tdata[43:28];
    assign in_byte      = s_axis_tdata[51:44];

    // derived configuration
    logic [8:0] w_eff, h_eff;
    logic [3:0] idx_bits;
    logic [7:0] idx_mask, slant_period;

    assign w_eff        = (r_cfg_width == 9'd0) ? 9'd1 : r_cfg_width;
    assign h_eff        = (r_cfg_height == 9'd0) ? 9'd1 : r_cfg_height;
    assign idx_bits     = index_bits(r_cfg_pal_count);
    assign idx_mask     = index_mask(idx_bits);
    assign slant_period = div3(h_eff);

    // one unpack step
    logic [4:0]  sh;
    logic [15:0] shifted;
    logic [7:0]  it_idx;
    logic [4:0]  it_held;
    logic [3:0]  it_taken;
    logic signed [11:0] sx, sy;
    logic        it_draw, it_cont, it_wrap, iter_end;
    logic [9:0]  col_inc;
    logic [8:0]  it_col, it_row;
    logic [7:0]  it_slant;
    logic signed [10:0] it_origin_x;

    assign sh       = r_held - 5'(idx_bits);
    assign shifted  = r_holder >> sh;
    assign it_idx   = shifted[7:0] & idx_mask;
    assign it_held  = sh;
    assign it_taken = r_taken + 4'd1;
    assign sx = {r_origin_x[10], r_origin_x} + $signed({3'b000, r_col});
    assign sy = {{2{r_origin_row[9]}}, r_origin_row} + $signed({3'b000, r_row});

    assign it_draw = r_busy && r_draw_on
                  && ({1'b0, it_idx} < r_cfg_pal_count)
                  && ({1'b0, it_idx} < 9'(PALETTE_DEPTH))
                  && ({1'b0, it_idx} != r_trans_slot)
                  && (sx >= 12'sd0) && (sx <= $signed(12'(CLIP_RIGHT)))
                  && (sy >= 12'sd0) && (sy < $signed({4'b0000, r_cfg_clip_bottom}));

    assign col_inc = {1'b0, r_col} + 10'd1;
    assign it_wrap = (col_inc >= {1'b0, w_eff});

    always_comb begin
        it_col      = col_inc[8:0];
        it_row      = r_row;
        it_slant    = r_slant;
        it_origin_x = r_origin_x;
        if (it_wrap) begin
            it_col = 9'd0;
            it_row = r_row + 9'd1;
            if (r_cfg_italic) begin
                // step the slant once per period of rows
                if (r_slant == slant_period) begin
                    it_slant    = 8'd0;
                    it_origin_x = r_origin_x - 11'sd1;
                end else begin
                    it_slant = r_slant + 8'd1;
                end
            end
        end
    end

    assign it_cont = (it_held >= 5'(idx_bits)) && (it_taken < 4'd8) && (it_row < h_eff);

    // handshake
    logic adv, acc, flush;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv && (!r_busy || !it_cont);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign iter_end      = r_busy && !it_cont;
    assign flush         = r_p_valid && (r_p_last || it_draw || iter_end);

    // start and palette word decode
    logic signed [10:0] start_x;
    logic [15:0] pal_word;
    logic        pal_in_range, pal_hit;

    assign start_x = $signed({in_pos_x[9], in_pos_x})
                   + (r_cfg_italic ? 11'sd2 : 11'sd0);
    assign pal_word     = in_pal_color | OPAQUE_BIT;
    assign pal_in_range = ({1'b0, in_pal_idx} < 9'(PALETTE_DEPTH));
    assign pal_hit      = (pal_word == (r_cfg_trans | OPAQUE_BIT));

    always_comb begin
        n_busy       = r_busy;
        n_taken      = r_taken;
        n_holder     = r_holder;
        n_held       = r_held;
        n_row        = r_row;
        n_col        = r_col;
        n_slant      = r_slant;
        n_origin_x   = r_origin_x;
        n_origin_row = r_origin_row;
        n_trans_slot = r_trans_slot;
        n_draw_on    = r_draw_on;
        if (adv && r_busy) begin
            n_taken    = it_taken;
            n_held     = it_cont ? it_held : {1'b0, it_held[3:0]};
            n_row      = it_row;
            n_col      = it_col;
            n_slant    = it_slant;
            n_origin_x = it_origin_x;
            if (!it_cont) begin
                n_busy = 1'b0;
            end
        end
        if (acc) begin
            case (in_op)
                OP_START: begin
                    n_origin_x   = start_x;
                    n_origin_row = $signed(in_pos_y);
                    n_holder     = 16'd0;
                    n_held       = 5'd0;
                    n_row        = 9'd0;
                    n_col        = 9'd0;
                    n_slant      = 8'd0;
                    n_trans_slot = NO_SLOT;
                    n_draw_on    = (start_x <= $signed(11'(CLIP_RIGHT)));
                end
                OP_PALETTE: begin
                    if (pal_in_range) begin
                        if (pal_hit) begin
                            n_trans_slot = {1'b0, in_pal_idx};
                        end else if (r_trans_slot == {1'b0, in_pal_idx}) begin
                            n_trans_slot = NO_SLOT;
                        end
                    end
                end
                OP_DATA: begin
                    // drop bytes once the sprite is complete
                    if (n_row < h_eff) begin
                        n_holder = {n_holder[7:0], in_byte};
                        n_held   = n_held + 5'd8;
                        n_taken  = 4'd0;
                        n_busy   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width       <= 9'd8;
            r_cfg_height      <= 9'd8;
            r_cfg_pal_count   <= 9'd2;
            r_cfg_trans       <= 16'h0000;
            r_cfg_mask        <= 16'hFFFF;
            r_cfg_invert      <= 1'b0;
            r_cfg_italic      <= 1'b0;
            r_cfg_clip_bottom <= 8'd191;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:       r_cfg_width       <= i_cfg_data[8:0];
                REG_HEIGHT:      r_cfg_height      <= i_cfg_data[8:0];
                REG_PAL_COUNT:   r_cfg_pal_count   <= i_cfg_data[8:0];
                REG_TRANSPARENT: r_cfg_trans       <= i_cfg_data;
                REG_COLOR_MASK:  r_cfg_mask        <= i_cfg_data;
                REG_INVERT:      r_cfg_invert      <= i_cfg_data[0];
                REG_ITALIC:      r_cfg_italic      <= i_cfg_data[0];
                REG_CLIP_BOTTOM: r_cfg_clip_bottom <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // unpack state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_taken      <= 4'd0;
            r_holder     <= 16'd0;
            r_held       <= 5'd0;
            r_row        <= 9'd0;
            r_col        <= 9'd0;
            r_slant      <= 8'd0;
            r_origin_x   <= 11'sd0;
            r_origin_row <= 10'sd0;
            r_trans_slot <= NO_SLOT;
            r_draw_on    <= 1'b1;
            r_p_valid    <= 1'b0;
            r_p_last     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_taken      <= n_taken;
            r_holder     <= n_holder;
            r_held       <= n_held;
            r_row        <= n_row;
            r_col        <= n_col;
            r_slant      <= n_slant;
            r_origin_x   <= n_origin_x;
            r_origin_row <= n_origin_row;
            r_trans_slot <= n_trans_slot;
            r_draw_on    <= n_draw_on;
            if (adv) begin
                // hold the newest pixel until it is known whether it closes the word
                if (it_draw) begin
                    r_p_valid <= 1'b1;
                    r_p_last  <= !it_cont;
                end else if (flush) begin
                    r_p_valid <= 1'b0;
                end
                r_out_valid <= flush;
                if (flush) begin
                    r_out_last <= r_p_last || (iter_end && !it_draw);
                end
            end
        end
    end

    // palette RAM and payload registers
    always_ff @(posedge i_clk) begin
        if (acc && (in_op == OP_PALETTE) && pal_in_range) begin
            r_pal_mem[in_pal_idx[PAL_AW-1:0]] <= pal_word;
        end
        if (adv && it_draw) begin
            r_p_entry <= r_pal_mem[it_idx[PAL_AW-1:0]];
            r_p_x     <= sx[7:0];
            r_p_y     <= sy[7:0];
        end
        if (adv && flush) begin
            r_out_x     <= r_p_x;
            r_out_y     <= r_p_y;
            r_out_color <= ((r_cfg_invert ? ~r_p_entry : r_p_entry) & r_cfg_mask)
                           | OPAQUE_BIT;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {r_out_color, r_out_y, r_out_x};

    `PPSB_ASSERT(a_pending_in_word, !(r_p_valid && !r_p_last) || r_busy, "pixel held without open word")
    `PPSB_ASSERT(a_taken_bound, !r_busy || (r_taken < 4'd8), "more than eight indices in one word")
    `PPSB_ASSERT_NEXT(a_stall_freeze, r_out_valid && !m_axis_tready, $stable(r_col) && $stable(r_busy) && $stable(r_p_valid), "unpack moved during output stall")

endmodule

`default_nettype wire

FILE: tb/ppsb_pixel_checker.sv
// ----------------------------------------------------------------------------
// Pixel write checker for the packed palette sprite blitter
// Mirrors register writes and accepted input words into a local copy of the
// blitter state, queues the screen writes each word should cause and compares
// every accepted output word against the oldest queued write.
// ----------------------------------------------------------------------------
module ppsb_pixel_checker
    import ppsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [55:0] i_in_data,
    input  logic [1:0]  i_in_op,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] color;
        logic        last;
    } pixel_write_t;

    pixel_write_t pixel_queue[$];

    // register copies
    logic [8:0]  spr_w;
    logic [8:0]  spr_h;
    logic [8:0]  pal_count;
    logic [15:0] key_color;
    logic [15:0] color_mask;
    logic        invert_on;
    logic        italic_on;
    logic [7:0]  clip_row;

    // unpack and placement state
    logic [15:0] palette_mem [PALETTE_DEPTH];
    logic [8:0]  key_slot;
    logic [15:0] bit_buf;
    int          bit_count;
    int          row_pos;
    int          col_pos;
    int          slant_pos;
    int          origin_x;
    int          origin_y;
    bit          draw_en;

    task automatic reset_state();
        spr_w      = 9'd8;
        spr_h      = 9'd8;
        pal_count  = 9'd2;
        key_color  = 16'h0000;
        color_mask = 16'hFFFF;
        invert_on  = 1'b0;
        italic_on  = 1'b0;
        clip_row   = 8'd191;
        key_slot   = NO_SLOT;
        bit_buf    = '0;
        bit_count  = 0;
        row_pos    = 0;
        col_pos    = 0;
        slant_pos  = 0;
        origin_x   = 0;
        origin_y   = 0;
        draw_en    = 1'b1;
    endtask

    task automatic apply_write(input logic [2:0] index, input logic [15:0] value);
        case (index)
            REG_WIDTH:       spr_w      = value[8:0];
            REG_HEIGHT:      spr_h      = value[8:0];
            REG_PAL_COUNT:   pal_count  = value[8:0];
            REG_TRANSPARENT: key_color  = value;
            REG_COLOR_MASK:  color_mask = value;
            REG_INVERT:      invert_on  = value[0];
            REG_ITALIC:      italic_on  = value[0];
            REG_CLIP_BOTTOM: clip_row   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic predict_writes(input logic [1:0] op, input logic [55:0] data);
        int           w;
        int           h;
        int           bits;
        int           taken;
        int           made;
        int           idx;
        int           sx;
        int           sy;
        logic [15:0]  entry;
        logic [15:0]  shade;
        pixel_write_t px;
        case (op)
            OP_START: begin
                origin_x  = int'($signed(data[9:0])) + (italic_on ? 2 : 0);
                origin_y  = int'($signed(data[19:10]));
                bit_buf   = '0;
                bit_count = 0;
                row_pos   = 0;
                col_pos   = 0;
                slant_pos = 0;
                key_slot  = NO_SLOT;
                draw_en   = (origin_x <= CLIP_RIGHT);
            end
            OP_PALETTE: begin
                idx   = int'(data[27:20]);
                entry = data[43:28] | OPAQUE_BIT;
                palette_mem[idx] = entry;
                if (entry == (key_color | OPAQUE_BIT))
                    key_slot = 9'(idx);
                else if (key_slot == 9'(idx))
                    key_slot = NO_SLOT;
            end
            OP_DATA: begin
                w = (spr_w == 9'd0) ? 1 : int'(spr_w);
                h = (spr_h == 9'd0) ? 1 : int'(spr_h);
                // smallest width that can address every entry, at most a byte
                bits = 1;
                while (bits < 8 && (1 << bits) < int'(pal_count))
                    bits++;
                taken = 0;
                made  = 0;
                if (row_pos < h) begin
                    bit_buf   = {bit_buf[7:0], data[51:44]};
                    bit_count = bit_count + 8;
                    while (bit_count >= bits && taken < 8 && row_pos < h) begin
                        idx = int'((bit_buf >> (bit_count - bits)) &
                                   ((16'd1 << bits) - 16'd1));
                        bit_count = bit_count - bits;
                        taken++;
                        if (draw_en && idx < int'(pal_count) && idx != int'(key_slot)) begin
                            sx = origin_x + col_pos;
                            sy = origin_y + row_pos;
                            if (sx >= 0 && sx <= CLIP_RIGHT && sy >= 0 &&
                                sy < int'(clip_row)) begin
                                entry    = palette_mem[idx];
                                shade    = ((invert_on ? ~entry : entry) & color_mask)
                                           | OPAQUE_BIT;
                                px.x     = sx[7:0];
                                px.y     = sy[7:0];
                                px.color = shade;
                                px.last  = 1'b0;
                                pixel_queue.push_back(px);
                                made++;
                            end
                        end
                        col_pos++;
                        if (col_pos >= w) begin
                            col_pos = 0;
                            row_pos++;
                            // slant: step the origin left once per period of rows
                            if (italic_on) begin
                                if (slant_pos == h / 3) begin
                                    slant_pos = 0;
                                    origin_x--;
                                end else begin
                                    slant_pos = (slant_pos + 1) & 255;
                                end
                            end
                        end
                    end
                    bit_count = bit_count & 15;
                    if (made > 0)
                        pixel_queue[pixel_queue.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        pixel_write_t got;
        pixel_write_t want;
        if (!i_rst_n) begin
            reset_state();
            pixel_queue.delete();
        end else begin
            if (i_cfg_we)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                got.x     = i_out_data[7:0];
                got.y     = i_out_data[15:8];
                got.color = i_out_data[31:16];
                got.last  = i_out_last;
                if (pixel_queue.size() == 0) begin
                    note_failure($sformatf("%0t: unexpected write x=%0d y=%0d c=%h last=%b",
                        $realtime, got.x, got.y, got.color, got.last));
                end else begin
                    want = pixel_queue.pop_front();
                    if (got !== want)
                        note_failure($sformatf(
                            "%0t: write mismatch exp x=%0d y=%0d c=%h last=%b, got x=%0d y=%0d c=%h last=%b",
                            $realtime, want.x, want.y, want.color, want.last,
                            got.x, got.y, got.color, got.last));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_writes(i_in_op, i_in_data);
        end
        o_pending = pixel_queue.size();
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the packed palette sprite blitter core
// Drives a directed sprite sequence and then random sprite phases, each with
// its own register setting, while the pixel checker predicts and compares the
// screen writes. Both stream sides idle in random bursts until the last phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppsb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS   = 130;
    localparam int SETTLE_CYCLES = 16;
    // worst case is far below this: every word fully drawn, every write stalled
    localparam int CYCLE_LIMIT   = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int          fail_count;
    int          pending_writes;
    int          cycle_count;
    int          items_sent;
    int          cur_w;
    int          cur_h;
    logic [8:0]  cur_count;
    logic [15:0] cur_transp;
    bit          gaps_on;
    bit          stalls_on;
    bit          palette_loaded [PALETTE_DEPTH];

    packed_palette_sprite_blitter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ppsb_pixel_checker u_pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_writes)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side: ready most of the time, stalls in random bursts while stalls_on is set
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready = 1'b0;
                stall = $urandom_range(0, 7);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // present one word and hold it until it is taken; valid stays high after
    task automatic send_word(input logic [1:0] op, input logic [55:0] data);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // unused fields carry random filler, the zero fill stays zero
    task automatic send_start(input logic [9:0] x, input logic [9:0] y);
        send_word(OP_START, {4'd0, 8'($urandom), 16'($urandom), 8'($urandom), y, x});
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [15:0] color);
        send_word(OP_PALETTE, {4'd0, 8'($urandom), color, idx, 20'($urandom)});
        palette_loaded[idx] = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_word(OP_DATA, {4'd0, value, 12'($urandom), 32'($urandom)});
    endtask

    // drop valid, drain expected writes, then let the unpack step finish
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_writes != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic configure(input logic [8:0] w, h, cnt, input logic [15:0] tc, mask,
                             input logic inv, ital, input logic [7:0] clip);
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_PAL_COUNT, 16'(cnt));
        write_reg(REG_TRANSPARENT, tc);
        write_reg(REG_COLOR_MASK, mask);
        write_reg(REG_INVERT, 16'(inv));
        write_reg(REG_ITALIC, 16'(ital));
        write_reg(REG_CLIP_BOTTOM, 16'(clip));
        cur_w      = (w == 9'd0) ? 1 : int'(w);
        cur_h      = (h == 9'd0) ? 1 : int'(h);
        cur_count  = cnt;
        cur_transp = tc;
    endtask

    // every entry that can be drawn must hold a color before any data
    task automatic load_palette();
        for (int i = 0; i < int'(cur_count) && i < PALETTE_DEPTH; i++)
            if (!palette_loaded[i])
                send_palette(8'(i), 16'($urandom));
    endtask

    function automatic logic [9:0] pick_origin(input int span);
        if ($urandom_range(0, 3) == 0)
            return 10'($urandom);
        return 10'(int'($urandom_range(0, span + 4)) - 4);
    endfunction

    initial begin
        logic [8:0]  w;
        logic [8:0]  h;
        logic [8:0]  cnt;
        logic [15:0] tc;
        logic [15:0] mask;
        logic [7:0]  clip;
        int          phase;
        int          nbytes;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_WIDTH;
        i_cfg_data    = '0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        cur_w         = 8;
        cur_h         = 8;
        cur_count     = 9'd2;
        cur_transp    = 16'h0000;
        items_sent    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset setting: 8x8, one bit per index, transparent color zero
        load_palette();
        send_start(10'd0, 10'd0);
        send_palette(8'd0, 16'h8000);
        send_palette(8'd1, 16'hFFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'hFF);
        send_byte(8'h81);
        // sprite is complete: this byte is dropped
        send_byte(8'hFF);
        send_word(OP_UNUSED, 56'h0F_FFFF_FFFF_FFFF);
        send_palette(8'd255, 16'h0000);

        // slanted narrow sprite, inverted and masked, clipped at row 4
        settle();
        configure(9'd3, 9'd9, 9'd5, 16'h1234, 16'h0F0F, 1'b1, 1'b1, 8'd4);
        load_palette();
        send_start(10'h3FE, 10'h3FF);
        send_palette(8'd3, 16'h9234);
        send_byte(8'h05);
        send_byte(8'h39);
        send_byte(8'h77);
        send_byte(8'hFF);
        send_byte(8'h00);
        // origins off the right edge and far off the top left draw nothing
        send_start(10'h1FF, 10'h1FF);
        send_byte(8'hFF);
        send_start(10'h200, 10'h200);
        send_byte(8'h00);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            if (items_sent >= TOTAL_ITEMS - 30) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 4) != 0);
                stalls_on = ($urandom_range(0, 4) != 0);
            end

            case ($urandom_range(0, 7))
                0:       w = 9'd256;
                1:       w = 9'd0;
                default: w = 9'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       h = 9'd256;
                1:       h = 9'd0;
                default: h = 9'($urandom_range(1, 12));
            endcase
            // counts stay small so the palette load fits the item budget
            case ($urandom_range(0, 9))
                0:       cnt = 9'd0;
                1:       cnt = 9'd33;
                default: cnt = 9'((1 << $urandom_range(0, 4)) + $urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 3))
                0:       tc = 16'h0000;
                1:       tc = 16'hFFFF;
                default: tc = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0, 1:    mask = 16'hFFFF;
                2:       mask = 16'h0000;
                default: mask = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       clip = 8'd0;
                1:       clip = 8'd255;
                2:       clip = 8'($urandom);
                default: clip = 8'd191;
            endcase
            // early phases pin the corner cases; the third continues the
            // previous sprite with a wider index, so leftover bits carry over
            case (phase)
                0: begin
                    w = 9'd0;
                    h = 9'd0;
                end
                1: begin
                    w   = 9'd256;
                    h   = 9'd256;
                    cnt = 9'd5;
                end
                2: cnt = 9'd17;
                3: begin
                    w    = 9'd256;
                    h    = 9'd2;
                    cnt  = 9'd33;
                    mask = 16'h0000;
                    clip = 8'd255;
                end
                4: cnt = 9'd0;
                default: ;
            endcase
            configure(w, h, cnt, tc, mask, 1'($urandom), 1'($urandom), clip);
            load_palette();

            if (phase != 2 && $urandom_range(0, 7) != 0) begin
                send_start(pick_origin(250), pick_origin(180));
                repeat ($urandom_range(0, 3)) begin
                    send_palette(8'($urandom_range(0, (cur_count > 0) ? cur_count - 1 : 0)),
                                 16'($urandom));
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_palette(8'($urandom_range(0, (cur_count > 0) ? cur_count - 1 : 0)),
                                 cur_transp ^ {1'($urandom), 15'd0});
                end
            end

            nbytes = cur_w * cur_h;
            if (nbytes > 20)
                nbytes = $urandom_range(6, 20);
            nbytes = nbytes + $urandom_range(0, 1);
            repeat (nbytes) begin
                // occasional noise inside the byte stream
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_word(OP_UNUSED, {4'd0, 52'({$urandom, $urandom})});
                        1: send_palette(8'($urandom), 16'($urandom));
                        default: send_start(pick_origin(250), pick_origin(180));
                    endcase
                end
                send_byte(8'($urandom));
            end
            phase++;
        end

        settle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: packed_palette_sprite_blitter_core.f
+incdir+rtl
rtl/ppsb_pkg.sv
rtl/packed_palette_sprite_blitter_core.sv
tb/ppsb_pixel_checker.sv
tb/tb.sv
